// ----- rtl/mtct_pkg.sv -----
package mtct_pkg;

   localparam int RES_MAX    = 16;                 // most words one item can cause
   localparam int RES_IDX_W  = $clog2(RES_MAX);
   localparam int RES_CNT_W  = RES_IDX_W + 1;
   localparam int SEG_MAX    = 8;                  // most words one translate step gives
   localparam int SEG_IDX_W  = $clog2(SEG_MAX);
   localparam int SEG_LEN_W  = SEG_IDX_W + 1;
   localparam int LEN_W      = 10;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [7:0]           byte_type;
   typedef logic [RES_IDX_W-1:0] idx_type;
   typedef logic [RES_CNT_W-1:0] cnt_type;
   typedef logic [SEG_IDX_W-1:0] seg_idx_type;
   typedef logic [SEG_LEN_W-1:0] seg_len_type;
   typedef logic [LEN_W-1:0]     len_type;

   localparam len_type  MAX_LENGTH_RST = len_type'(400);
   localparam logic [0:0] REG_MAX_LENGTH = 1'b0;

   localparam byte_type CH_NUL    = 8'h00;
   localparam byte_type CH_SPACE  = 8'h20;
   localparam byte_type CH_BANG   = 8'h21;
   localparam byte_type CH_AMP    = 8'h26;
   localparam byte_type CH_QUOTE  = 8'h27;
   localparam byte_type CH_LPAREN = 8'h28;
   localparam byte_type CH_RPAREN = 8'h29;
   localparam byte_type CH_STAR   = 8'h2A;
   localparam byte_type CH_PLUS   = 8'h2B;
   localparam byte_type CH_MINUS  = 8'h2D;
   localparam byte_type CH_SLASH  = 8'h2F;
   localparam byte_type CH_LT     = 8'h3C;
   localparam byte_type CH_EQ     = 8'h3D;
   localparam byte_type CH_GT     = 8'h3E;
   localparam byte_type CH_LBRACK = 8'h5B;
   localparam byte_type CH_BSLASH = 8'h5C;
   localparam byte_type CH_RBRACK = 8'h5D;
   localparam byte_type CH_CARET  = 8'h5E;
   localparam byte_type CH_F      = 8'h66;
   localparam byte_type CH_I      = 8'h69;
   localparam byte_type CH_L      = 8'h6C;
   localparam byte_type CH_M      = 8'h6D;
   localparam byte_type CH_S      = 8'h73;
   localparam byte_type CH_PIPE   = 8'h7C;
   localparam byte_type CH_TILDE  = 8'h7E;

   typedef enum logic [3:0] {
      M_IDLE  = 4'd0,
      M_OP    = 4'd1,
      M_ESC2  = 4'd2,
      M_ESC3  = 4'd3,
      M_ESC4P = 4'd4,
      M_ESC4S = 4'd5,
      M_ESC5  = 4'd6
   } hold_mode_type;

   // words of one translate step; mid marks the second word of a spacer
   typedef struct packed {
      seg_len_type               len;
      logic [SEG_MAX-1:0]        mid;
      logic [SEG_MAX-1:0][7:0]   bytes;
   } seg_type;

   function automatic byte_type spacer_key(input byte_type prev);
      byte_type k;
      unique case (prev)
         CH_PIPE:  k = CH_CARET;
         CH_CARET: k = CH_AMP;
         CH_AMP:   k = CH_BANG;
         default:  k = CH_PIPE;
      endcase
      return k;
   endfunction

   function automatic seg_type one_byte(input byte_type b);
      seg_type s;
      s          = '0;
      s.len      = seg_len_type'(1);
      s.bytes[0] = b;
      return s;
   endfunction

   function automatic seg_type char_name(input byte_type a, input byte_type b);
      seg_type s;
      s          = '0;
      s.len      = seg_len_type'(4);
      s.bytes[0] = CH_BSLASH;
      s.bytes[1] = CH_LPAREN;
      s.bytes[2] = a;
      s.bytes[3] = b;
      return s;
   endfunction

   // spacer, then the arrow name
   function automatic seg_type arrow(input byte_type prev);
      seg_type s;
      s          = '0;
      s.len      = seg_len_type'(6);
      s.bytes[0] = CH_BSLASH;
      s.bytes[1] = spacer_key(prev);
      s.mid[1]   = 1'b1;
      s.bytes[2] = CH_BSLASH;
      s.bytes[3] = CH_LPAREN;
      s.bytes[4] = CH_MINUS;
      s.bytes[5] = CH_GT;
      return s;
   endfunction

   // spaced operator; minus turns into its name
   function automatic seg_type single_op(input byte_type c, input byte_type prev);
      seg_type s;
      s          = '0;
      s.bytes[0] = CH_BSLASH;
      s.bytes[1] = spacer_key(prev);
      s.mid[1]   = 1'b1;
      if (c == CH_MINUS) begin
         s.len      = seg_len_type'(8);
         s.bytes[2] = CH_BSLASH;
         s.bytes[3] = CH_LPAREN;
         s.bytes[4] = CH_M;
         s.bytes[5] = CH_I;
         s.bytes[6] = CH_BSLASH;
         s.bytes[7] = spacer_key(CH_I);
         s.mid[7]   = 1'b1;
      end else begin
         s.len      = seg_len_type'(5);
         s.bytes[2] = c;
         s.bytes[3] = CH_BSLASH;
         s.bytes[4] = spacer_key(c);
         s.mid[4]   = 1'b1;
      end
      return s;
   endfunction

   function automatic seg_type xlate(input byte_type c, input logic last, input byte_type prev);
      seg_type  s;
      byte_type k;
      s = '0;
      k = spacer_key(prev);
      case (c) inside
         CH_LPAREN, CH_LBRACK, CH_RPAREN, CH_RBRACK: begin
            s.len      = seg_len_type'(3);
            s.bytes[0] = CH_BSLASH;
            s.bytes[1] = k;
            s.mid[1]   = 1'b1;
            s.bytes[2] = c;
         end
         CH_PLUS, CH_PIPE: begin
            s.len      = seg_len_type'(5);
            s.bytes[0] = CH_BSLASH;
            s.bytes[1] = k;
            s.mid[1]   = 1'b1;
            s.bytes[2] = c;
            s.bytes[3] = CH_BSLASH;
            s.bytes[4] = spacer_key(c);
            s.mid[4]   = 1'b1;
         end
         CH_EQ, CH_LT, CH_GT, CH_MINUS: begin
            // held for lookahead unless the token ends here
            if (last) begin
               s = single_op(c, prev);
            end
         end
         CH_SLASH: begin
            s = char_name(CH_S, CH_L);
         end
         CH_QUOTE: begin
            s = char_name(CH_F, CH_M);
         end
         CH_TILDE, CH_SPACE: begin
            s.len      = seg_len_type'(4);
            s.bytes[0] = CH_BSLASH;
            s.bytes[1] = k;
            s.mid[1]   = 1'b1;
            s.bytes[2] = CH_BSLASH;
            s.bytes[3] = spacer_key(k);
            s.mid[3]   = 1'b1;
         end
         CH_CARET: begin
            s.len      = seg_len_type'(2);
            s.bytes[0] = CH_BSLASH;
            s.bytes[1] = k;
            s.mid[1]   = 1'b1;
         end
         default: begin
            s = one_byte(c);
         end
      endcase
      return s;
   endfunction

   function automatic hold_mode_type xlate_hold(input byte_type c, input logic last);
      hold_mode_type m;
      m = M_IDLE;
      if (!last) begin
         case (c) inside
            CH_EQ, CH_LT, CH_GT, CH_MINUS: m = M_OP;
            CH_BSLASH:                     m = M_ESC2;
            default:                       m = M_IDLE;
         endcase
      end
      return m;
   endfunction

endpackage

// ----- rtl/math_text_char_translator.sv -----
// Equation token character translator.
//
// Input channel (req_*): one token character per word, req_token_end on the
// token's final character. Result channel (rsp_*): typesetter bytes, one per
// word; rsp_run_last marks the last word caused by an input word,
// rsp_token_done the last word of the token, rsp_overflow a refused append.
// Some input words cause no result word (held lookahead, dropped characters
// after an overflow); a token end always causes at least one.
// Config: APB-style port, max_length at byte address 0 (10 bits, reset 400).
// Write only while no word is in flight.
//
// Path: input register, then result buffer, from which result words leave.
// Throughput: an input word with N result words (0..16) is translated once the
// result buffer is free, or while it drains if N is 0; the buffer drains one
// word per cycle while rsp_ready is high, and the next input word is translated
// in the cycle its last word leaves, so a new word is accepted while results still wait.
// Stall: a low rsp_ready holds the current word; the input register then
// fills and req_ready drops.
// Reset (synchronous): empties both stages, clears the token state and sets
// max_length back to 400.
module math_text_char_translator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_char_in,
   input  logic                               req_token_end,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_run_last,
   output logic                               rsp_token_done,
   output logic                               rsp_overflow,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mtct_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mtct_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mtct_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   // ---------------- config register
   mtct_pkg::len_type max_length_ff;
   logic              csr_sel_max;

   assign pready      = 1'b1;
   assign csr_sel_max = (paddr[mtct_pkg::CSR_ADDR_W-1] == mtct_pkg::REG_MAX_LENGTH);
   assign prdata      = csr_sel_max ?
                        mtct_pkg::CSR_DATA_W'(max_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= mtct_pkg::MAX_LENGTH_RST;
      end else if (psel && penable && pwrite && pready && csr_sel_max) begin
         max_length_ff <= pwdata[mtct_pkg::LEN_W-1:0];
      end
   end

   // ---------------- input register
   logic                in_vld_ff;
   mtct_pkg::byte_type  char_ff;
   logic                last_ff;
   logic                fire;          // translate the held word this cycle

   assign req_ready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_vld_ff <= 1'b1;
      end else if (fire) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_char_in;
         last_ff <= req_token_end;
      end
   end

   // ---------------- token state
   mtct_pkg::hold_mode_type hold_mode_ff, hold_mode_in;
   mtct_pkg::byte_type      held_char_ff, held_char_in;
   mtct_pkg::byte_type      esc_second_ff, esc_second_in;
   mtct_pkg::byte_type      last_out_ff, last_out_in;
   mtct_pkg::len_type       out_count_ff, out_count_in;
   logic                    overflowed_ff, overflowed_in;

   // Words of this step: seg1 from the held operator or escape, seg2 the
   // translation of the new character where the held one did not absorb it.
   mtct_pkg::seg_type seg1, seg2;

   always_comb begin : p_segments
      seg1 = '0;
      seg2 = '0;
      if (!overflowed_ff) begin
         unique case (hold_mode_ff)
            mtct_pkg::M_OP: begin
               if ((held_char_ff != mtct_pkg::CH_MINUS) && (char_ff == mtct_pkg::CH_EQ)) begin
                  seg1 = mtct_pkg::char_name(held_char_ff, mtct_pkg::CH_EQ);
               end else if ((held_char_ff == mtct_pkg::CH_MINUS) &&
                            (char_ff == mtct_pkg::CH_GT)) begin
                  seg1 = mtct_pkg::arrow(last_out_ff);
               end else begin
                  seg1 = mtct_pkg::single_op(held_char_ff, last_out_ff);
                  seg2 = mtct_pkg::xlate(char_ff, last_ff,
                            seg1.bytes[mtct_pkg::seg_idx_type'(seg1.len - 1'b1)]);
               end
            end
            mtct_pkg::M_ESC2, mtct_pkg::M_ESC3, mtct_pkg::M_ESC4P: begin
               seg1 = mtct_pkg::one_byte(char_ff);
            end
            mtct_pkg::M_ESC4S: begin
               // lone fourth character at token end is translated as usual
               if (last_ff) begin
                  seg1 = mtct_pkg::xlate(char_ff, 1'b1, last_out_ff);
               end
            end
            mtct_pkg::M_ESC5: begin
               seg1 = mtct_pkg::one_byte(held_char_ff);
               seg2 = mtct_pkg::one_byte(char_ff);
            end
            default: begin
               seg1 = mtct_pkg::xlate(char_ff, last_ff, last_out_ff);
            end
         endcase
      end
   end

   always_comb begin : p_next_hold
      hold_mode_in  = mtct_pkg::M_IDLE;
      held_char_in  = held_char_ff;
      esc_second_in = esc_second_ff;
      if (overflowed_ff) begin
         hold_mode_in = hold_mode_ff;
      end else begin
         unique case (hold_mode_ff)
            mtct_pkg::M_OP: begin
               if (!(((held_char_ff != mtct_pkg::CH_MINUS) && (char_ff == mtct_pkg::CH_EQ)) ||
                     ((held_char_ff == mtct_pkg::CH_MINUS) && (char_ff == mtct_pkg::CH_GT))))
               begin
                  hold_mode_in = mtct_pkg::xlate_hold(char_ff, last_ff);
                  if (hold_mode_in == mtct_pkg::M_OP) begin
                     held_char_in = char_ff;
                  end
               end
            end
            mtct_pkg::M_ESC2: begin
               esc_second_in = char_ff;
               if (!last_ff) begin
                  hold_mode_in = mtct_pkg::M_ESC3;
               end
            end
            mtct_pkg::M_ESC3: begin
               if (!last_ff) begin
                  if (esc_second_ff == mtct_pkg::CH_LPAREN) begin
                     hold_mode_in = mtct_pkg::M_ESC4P;
                  end else if ((esc_second_ff == mtct_pkg::CH_STAR) &&
                               (char_ff == mtct_pkg::CH_LPAREN)) begin
                     hold_mode_in = mtct_pkg::M_ESC4S;
                  end
               end
            end
            mtct_pkg::M_ESC4P: begin
               hold_mode_in = mtct_pkg::M_IDLE;
            end
            mtct_pkg::M_ESC4S: begin
               if (!last_ff) begin
                  held_char_in = char_ff;
                  hold_mode_in = mtct_pkg::M_ESC5;
               end
            end
            mtct_pkg::M_ESC5: begin
               hold_mode_in = mtct_pkg::M_IDLE;
            end
            default: begin
               hold_mode_in = mtct_pkg::xlate_hold(char_ff, last_ff);
               if (hold_mode_in == mtct_pkg::M_OP) begin
                  held_char_in = char_ff;
               end
            end
         endcase
      end
      if (last_ff) begin
         hold_mode_in  = mtct_pkg::M_IDLE;
         held_char_in  = mtct_pkg::CH_NUL;
         esc_second_in = mtct_pkg::CH_NUL;
      end
   end

   // ---------------- join seg1 and seg2 into one word stream
   mtct_pkg::byte_type     strm_byte [mtct_pkg::RES_MAX];
   logic [mtct_pkg::RES_MAX-1:0] strm_mid;
   mtct_pkg::cnt_type      rel_idx   [mtct_pkg::RES_MAX];
   mtct_pkg::cnt_type      strm_len;

   assign strm_len = mtct_pkg::cnt_type'(seg1.len) + mtct_pkg::cnt_type'(seg2.len);

   always_comb begin : p_join
      for (int k = 0; k < mtct_pkg::RES_MAX; k++) begin
         rel_idx[k] = mtct_pkg::cnt_type'(k) - mtct_pkg::cnt_type'(seg1.len);
         if (mtct_pkg::cnt_type'(k) < mtct_pkg::cnt_type'(seg1.len)) begin
            strm_byte[k] = seg1.bytes[mtct_pkg::seg_idx_type'(k)];
            strm_mid[k]  = seg1.mid[mtct_pkg::seg_idx_type'(k)];
         end else if (rel_idx[k] < mtct_pkg::cnt_type'(mtct_pkg::SEG_MAX)) begin
            strm_byte[k] = seg2.bytes[rel_idx[k][mtct_pkg::SEG_IDX_W-1:0]];
            strm_mid[k]  = seg2.mid[rel_idx[k][mtct_pkg::SEG_IDX_W-1:0]];
         end else begin
            strm_byte[k] = mtct_pkg::CH_NUL;
            strm_mid[k]  = 1'b0;
         end
      end
   end

   // ---------------- length limit
   // Appends are refused once count + size reaches max_length; a spacer is
   // all or nothing, so a cut inside one backs off to its start.
   logic                        refuse;
   logic                        room_none;
   mtct_pkg::idx_type           room;
   mtct_pkg::idx_type           cut;
   mtct_pkg::cnt_type           emitted;
   logic                        empty_last;
   mtct_pkg::cnt_type           n_res;
   logic                        zero_en;
   mtct_pkg::idx_type           zero_pos;
   logic                        ovf_flag;

   assign refuse    = (strm_len != '0) &&
                      (({1'b0, out_count_ff} + (mtct_pkg::LEN_W+1)'(strm_len)) >=
                       {1'b0, max_length_ff});
   assign room_none = (out_count_ff >= max_length_ff);
   assign room      = mtct_pkg::idx_type'(max_length_ff - out_count_ff - 1'b1);
   assign cut       = room_none    ? '0 :
                      strm_mid[room] ? room - 1'b1 : room;
   assign emitted   = refuse ? mtct_pkg::cnt_type'(cut) : strm_len;
   assign empty_last = last_ff && !refuse && (strm_len == '0);
   assign n_res     = refuse     ? mtct_pkg::cnt_type'(cut) + 1'b1 :
                      empty_last ? mtct_pkg::cnt_type'(1) : strm_len;
   assign zero_en   = refuse || empty_last;
   assign zero_pos  = refuse ? cut : '0;
   assign ovf_flag  = refuse || (empty_last && overflowed_ff);

   always_comb begin : p_next_count
      last_out_in   = last_out_ff;
      out_count_in  = out_count_ff + mtct_pkg::len_type'(emitted);
      overflowed_in = overflowed_ff || refuse;
      if (emitted != '0) begin
         last_out_in = strm_byte[mtct_pkg::idx_type'(emitted - 1'b1)];
      end
      if (last_ff) begin
         last_out_in   = mtct_pkg::CH_NUL;
         out_count_in  = '0;
         overflowed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_mode_ff  <= mtct_pkg::M_IDLE;
         held_char_ff  <= mtct_pkg::CH_NUL;
         esc_second_ff <= mtct_pkg::CH_NUL;
         last_out_ff   <= mtct_pkg::CH_NUL;
         out_count_ff  <= '0;
         overflowed_ff <= 1'b0;
      end else if (fire) begin
         hold_mode_ff  <= hold_mode_in;
         held_char_ff  <= held_char_in;
         esc_second_ff <= esc_second_in;
         last_out_ff   <= last_out_in;
         out_count_ff  <= out_count_in;
         overflowed_ff <= overflowed_in;
      end
   end

   // ---------------- result buffer, drained one word per cycle while rsp_ready is high
   logic                 buf_vld_ff, buf_vld_in;
   mtct_pkg::idx_type    rd_idx_ff, rd_idx_in;
   mtct_pkg::idx_type    buf_last_ff;
   logic                 buf_tok_ff;
   logic                 buf_ovf_ff;
   mtct_pkg::byte_type   buf_byte_ff [mtct_pkg::RES_MAX];
   mtct_pkg::byte_type   buf_byte_in [mtct_pkg::RES_MAX];
   logic                 at_last;
   logic                 buf_free;
   logic                 load;

   assign at_last  = (rd_idx_ff == buf_last_ff);
   assign buf_free = !buf_vld_ff || (rsp_ready && at_last);
   // words that cause no result pass even while the buffer drains
   assign fire     = in_vld_ff && ((n_res == '0) || buf_free);
   assign load     = fire && (n_res != '0);

   always_comb begin : p_buf_next
      buf_vld_in = buf_vld_ff;
      rd_idx_in  = rd_idx_ff;
      if (buf_vld_ff && rsp_ready) begin
         rd_idx_in = rd_idx_ff + 1'b1;
         if (at_last) begin
            buf_vld_in = 1'b0;
         end
      end
      if (load) begin
         buf_vld_in = 1'b1;
         rd_idx_in  = '0;
      end
      for (int k = 0; k < mtct_pkg::RES_MAX; k++) begin
         buf_byte_in[k] = (zero_en && (zero_pos == mtct_pkg::idx_type'(k))) ?
                          mtct_pkg::CH_NUL : strm_byte[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_vld_ff <= 1'b0;
         rd_idx_ff  <= '0;
      end else begin
         buf_vld_ff <= buf_vld_in;
         rd_idx_ff  <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_last_ff <= mtct_pkg::idx_type'(n_res - 1'b1);
         buf_tok_ff  <= last_ff;
         buf_ovf_ff  <= ovf_flag;
         for (int k = 0; k < mtct_pkg::RES_MAX; k++) begin
            buf_byte_ff[k] <= buf_byte_in[k];
         end
      end
   end

   assign rsp_valid      = buf_vld_ff;
   assign rsp_out_byte   = buf_byte_ff[rd_idx_ff];
   assign rsp_run_last   = at_last;
   assign rsp_token_done = at_last && buf_tok_ff;
   assign rsp_overflow   = at_last && buf_ovf_ff;

endmodule

// ----- rtl/mtct_checker.sv -----
module mtct_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_token_done,
   input logic       rsp_overflow
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_run_last) && $stable(rsp_token_done) && $stable(rsp_overflow))
      else $error("result word changed while stalled");

   a_done_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_done |-> rsp_run_last)
      else $error("token end not on last word of its run");

   a_ovf_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_run_last && (rsp_out_byte == 8'h00))
      else $error("overflow word not a zero closing word");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_reset_req: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

endmodule

bind math_text_char_translator mtct_checker u_mtct_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_run_last   (rsp_run_last),
   .rsp_token_done (rsp_token_done),
   .rsp_overflow   (rsp_overflow)
);

// ----- sim/tb.sv -----
module tb;

   // run shape
   localparam int LIMIT       = 200000;  // cycles before the run is declared hung
   localparam int DRAIN       = 8;       // settle cycles after the last byte
   localparam int PHASES      = 7;
   localparam int PHASE_WORDS = 55;      // random chars per length setting
   localparam int IDLE_PCT    = 12;

   typedef struct packed {
      mtct_pkg::byte_type ch;
      logic               fin;
   } req_word_type;

   typedef struct packed {
      mtct_pkg::byte_type out_byte;
      logic               run_last;
      logic               token_done;
      logic               overflow;
   } rsp_word_type;

   // ------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ------------------------------------------------------------------
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_char_in = '0;
   logic                            req_token_end = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [7:0]                      rsp_out_byte;
   logic                            rsp_run_last;
   logic                            rsp_token_done;
   logic                            rsp_overflow;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [mtct_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [mtct_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [mtct_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   math_text_char_translator dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_in    (req_char_in),
      .req_token_end  (req_token_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_token_done (rsp_token_done),
      .rsp_overflow   (rsp_overflow),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // shared bookkeeping
   // ------------------------------------------------------------------
   req_word_type       pending_words[$];   // chars waiting for the driver
   rsp_word_type       expected_bytes[$];  // predicted output bytes, oldest first
   rsp_word_type       step_words[$];      // bytes caused by the char being predicted
   mtct_pkg::byte_type draft[$];           // token under construction

   int  cycles = 0;
   int  fails = 0;
   int  words_queued = 0;
   int  words_taken = 0;
   int  tokens_taken = 0;
   int  bytes_seen = 0;
   int  refusals = 0;
   int  settings_run = 0;
   bit  quiet = 1'b0;                // set for a stretch with no idling on either side

   mtct_pkg::byte_type op_chars[4] = '{mtct_pkg::CH_EQ, mtct_pkg::CH_LT,
                                       mtct_pkg::CH_GT, mtct_pkg::CH_MINUS};
   mtct_pkg::byte_type special_chars[18] = '{
      mtct_pkg::CH_LPAREN, mtct_pkg::CH_RPAREN, mtct_pkg::CH_LBRACK, mtct_pkg::CH_RBRACK,
      mtct_pkg::CH_PLUS, mtct_pkg::CH_PIPE, mtct_pkg::CH_SLASH, mtct_pkg::CH_QUOTE,
      mtct_pkg::CH_TILDE, mtct_pkg::CH_SPACE, mtct_pkg::CH_CARET, mtct_pkg::CH_BSLASH,
      mtct_pkg::CH_AMP, mtct_pkg::CH_BANG, mtct_pkg::CH_STAR, mtct_pkg::CH_EQ,
      mtct_pkg::CH_MINUS, mtct_pkg::CH_NUL};

   task automatic flag_mismatch(input string msg);
      fails++;
      $display("[%0d] mismatch: %s", cycles, msg);
   endtask

   // ------------------------------------------------------------------
   // predictor: token state and the length limit as the block keeps them
   // ------------------------------------------------------------------
   mtct_pkg::hold_mode_type tk_mode = mtct_pkg::M_IDLE;
   mtct_pkg::byte_type      tk_held = '0;
   mtct_pkg::byte_type      tk_esc2 = '0;      // second char of an escape
   mtct_pkg::byte_type      tk_last = '0;      // last byte put out, zero before the first
   int                      tk_count = 0;      // bytes put out in this token
   logic                    tk_ovf = 1'b0;
   int                      cfg_max_len = int'(mtct_pkg::MAX_LENGTH_RST);

   function automatic void put_word(input mtct_pkg::byte_type b, input logic ovf);
      rsp_word_type w;
      if (step_words.size() < mtct_pkg::RES_MAX) begin
         w = '{b, 1'b0, 1'b0, ovf};
         step_words.push_back(w);
      end
   endfunction

   // a refused append yields one zero byte flagged overflow and kills the token
   function automatic void append1(input mtct_pkg::byte_type b);
      if (!tk_ovf) begin
         if (tk_count + 1 >= cfg_max_len) begin
            tk_ovf = 1'b1;
            put_word(mtct_pkg::CH_NUL, 1'b1);
         end else begin
            put_word(b, 1'b0);
            tk_count++;
            tk_last = b;
         end
      end
   endfunction

   // pairs (spacers) go out whole or not at all
   function automatic void append2(input mtct_pkg::byte_type a, input mtct_pkg::byte_type b);
      if (!tk_ovf) begin
         if (tk_count + 2 >= cfg_max_len) begin
            tk_ovf = 1'b1;
            put_word(mtct_pkg::CH_NUL, 1'b1);
         end else begin
            put_word(a, 1'b0);
            put_word(b, 1'b0);
            tk_count += 2;
            tk_last = b;
         end
      end
   endfunction

   // spacer key rotates so two spacers in a row never look alike
   function automatic void add_spacer();
      mtct_pkg::byte_type k;
      case (tk_last)
         mtct_pkg::CH_PIPE:  k = mtct_pkg::CH_CARET;
         mtct_pkg::CH_CARET: k = mtct_pkg::CH_AMP;
         mtct_pkg::CH_AMP:   k = mtct_pkg::CH_BANG;
         default:            k = mtct_pkg::CH_PIPE;
      endcase
      append2(mtct_pkg::CH_BSLASH, k);
   endfunction

   // two-letter char name, refused byte by byte
   function automatic void add_name(input mtct_pkg::byte_type a, input mtct_pkg::byte_type b);
      append1(mtct_pkg::CH_BSLASH);
      append1(mtct_pkg::CH_LPAREN);
      append1(a);
      append1(b);
   endfunction

   function automatic void add_spaced_op(input mtct_pkg::byte_type c);
      add_spacer();
      if (c == mtct_pkg::CH_MINUS) begin
         add_name(mtct_pkg::CH_M, mtct_pkg::CH_I);
      end else begin
         append1(c);
      end
      add_spacer();
   endfunction

   function automatic void convert_char(input mtct_pkg::byte_type c, input logic is_end);
      case (c)
         mtct_pkg::CH_LPAREN, mtct_pkg::CH_LBRACK,
         mtct_pkg::CH_RPAREN, mtct_pkg::CH_RBRACK: begin
            add_spacer();
            append1(c);
         end
         mtct_pkg::CH_PLUS, mtct_pkg::CH_PIPE: begin
            add_spacer();
            append1(c);
            add_spacer();
         end
         mtct_pkg::CH_EQ, mtct_pkg::CH_LT, mtct_pkg::CH_GT, mtct_pkg::CH_MINUS: begin
            // comparison / minus waits for its follower unless the token ends
            if (is_end) begin
               add_spaced_op(c);
            end else begin
               tk_mode = mtct_pkg::M_OP;
               tk_held = c;
            end
         end
         mtct_pkg::CH_SLASH: add_name(mtct_pkg::CH_S, mtct_pkg::CH_L);
         mtct_pkg::CH_QUOTE: add_name(mtct_pkg::CH_F, mtct_pkg::CH_M);
         mtct_pkg::CH_TILDE, mtct_pkg::CH_SPACE: begin
            add_spacer();
            add_spacer();
         end
         mtct_pkg::CH_CARET: add_spacer();
         mtct_pkg::CH_BSLASH: begin
            append1(mtct_pkg::CH_BSLASH);
            if (!is_end) begin
               tk_mode = mtct_pkg::M_ESC2;
            end
         end
         default:            append1(c);
      endcase
   endfunction

   // works out every byte one accepted char causes and queues them
   function automatic void predict_word(input mtct_pkg::byte_type c, input logic is_end);
      mtct_pkg::hold_mode_type mode;
      mtct_pkg::byte_type      h;
      rsp_word_type            w;
      int                      n;
      mode = tk_mode;
      h    = tk_held;
      step_words.delete();
      if (!tk_ovf) begin
         tk_mode = mtct_pkg::M_IDLE;
         case (mode)
            mtct_pkg::M_OP: begin
               if (h != mtct_pkg::CH_MINUS && c == mtct_pkg::CH_EQ) begin
                  add_name(h, mtct_pkg::CH_EQ);
               end else if (h == mtct_pkg::CH_MINUS && c == mtct_pkg::CH_GT) begin
                  add_spacer();
                  add_name(mtct_pkg::CH_MINUS, mtct_pkg::CH_GT);
               end else begin
                  add_spaced_op(h);
                  convert_char(c, is_end);
               end
            end
            mtct_pkg::M_ESC2: begin
               append1(c);
               tk_esc2 = c;
               if (!is_end) begin
                  tk_mode = mtct_pkg::M_ESC3;
               end
            end
            mtct_pkg::M_ESC3: begin
               append1(c);
               if (!is_end) begin
                  if (tk_esc2 == mtct_pkg::CH_LPAREN) begin
                     tk_mode = mtct_pkg::M_ESC4P;
                  end else if (tk_esc2 == mtct_pkg::CH_STAR && c == mtct_pkg::CH_LPAREN) begin
                     tk_mode = mtct_pkg::M_ESC4S;
                  end
               end
            end
            mtct_pkg::M_ESC4P: append1(c);
            mtct_pkg::M_ESC4S: begin
               // a lone fourth char that ends the token is an ordinary char
               if (is_end) begin
                  convert_char(c, 1'b1);
               end else begin
                  tk_held = c;
                  tk_mode = mtct_pkg::M_ESC5;
               end
            end
            mtct_pkg::M_ESC5: begin
               append1(h);
               append1(c);
            end
            default: convert_char(c, is_end);
         endcase
      end
      // a token end that puts nothing out still closes the token
      if (is_end && step_words.size() == 0) begin
         put_word(mtct_pkg::CH_NUL, tk_ovf);
      end
      n = step_words.size();
      if (n > 0) begin
         w = step_words[n-1];
         w.run_last = 1'b1;
         w.token_done = is_end;
         step_words[n-1] = w;
      end
      foreach (step_words[i]) begin
         expected_bytes.push_back(step_words[i]);
      end
      if (is_end) begin
         tk_mode  = mtct_pkg::M_IDLE;
         tk_held  = '0;
         tk_esc2  = '0;
         tk_last  = '0;
         tk_count = 0;
         tk_ovf   = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------
   // input driver: holds a word until taken, idles at random between words
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      req_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_ready)) begin
         if (pending_words.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
            w = pending_words.pop_front();
            req_valid     <= 1'b1;
            req_char_in   <= w.ch;
            req_token_end <= w.fin;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // ------------------------------------------------------------------
   // monitor: predict on every taken char, check every taken byte
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_word(req_char_in, req_token_end);
            words_taken++;
            if (req_token_end) begin
               tokens_taken++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_byte, rsp_run_last, rsp_token_done, rsp_overflow};
            bytes_seen++;
            if (rsp_overflow) begin
               refusals++;
            end
            if (expected_bytes.size() == 0) begin
               flag_mismatch($sformatf("unexpected byte %02h last=%b done=%b ovf=%b",
                  got.out_byte, got.run_last, got.token_done, got.overflow));
            end else begin
               want = expected_bytes.pop_front();
               if (got !== want) begin
                  flag_mismatch($sformatf(
                     "byte %02h/%02h last %b/%b done %b/%b ovf %b/%b (got/want)",
                     got.out_byte, want.out_byte, got.run_last, want.run_last,
                     got.token_done, want.token_done, got.overflow, want.overflow));
               end
            end
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   task automatic draft_str(input string s);
      for (int i = 0; i < s.len(); i++) begin
         draft.push_back(mtct_pkg::byte_type'(s[i]));
      end
   endtask

   function automatic mtct_pkg::byte_type any_byte();
      return mtct_pkg::byte_type'($urandom_range(0, 255));
   endfunction

   // one chunk of a token: mostly well-formed constructs, some raw noise
   task automatic draft_piece();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         draft.push_back(any_byte());
      end else if (sel < 42) begin
         // comparison or arrow candidate
         draft.push_back(op_chars[$urandom_range(0, 3)]);
         draft.push_back($urandom_range(0, 1) ? mtct_pkg::CH_EQ : mtct_pkg::CH_GT);
      end else if (sel < 60) begin
         draft.push_back(mtct_pkg::CH_BSLASH);
         case ($urandom_range(0, 3))
            0: begin
               draft.push_back(mtct_pkg::CH_LPAREN);
               draft.push_back(any_byte());
               draft.push_back(any_byte());
            end
            1: begin
               draft.push_back(mtct_pkg::CH_STAR);
               draft.push_back(mtct_pkg::CH_LPAREN);
               draft.push_back(any_byte());
               draft.push_back(any_byte());
            end
            2: begin
               draft.push_back(mtct_pkg::CH_STAR);
               draft.push_back(mtct_pkg::CH_LPAREN);
               draft.push_back(any_byte());
            end
            default: begin
               draft.push_back(any_byte());
               draft.push_back(any_byte());
            end
         endcase
      end else if (sel < 85) begin
         draft.push_back(special_chars[$urandom_range(0, 17)]);
      end else begin
         draft.push_back(mtct_pkg::byte_type'($urandom_range(48, 122)));
      end
   endtask

   // hands the drafted token to the driver, end mark on its last char
   task automatic commit_token();
      req_word_type w;
      foreach (draft[i]) begin
         w.ch  = draft[i];
         w.fin = (i == draft.size() - 1);
         pending_words.push_back(w);
      end
      words_queued += draft.size();
      draft.delete();
   endtask

   // every queued char taken and every predicted byte seen, then a short settle
   task automatic wait_drain();
      while (words_taken != words_queued || expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN) @(posedge clock);
   endtask

   // APB-style access: setup cycle, then access cycle, then read data is sampled
   task automatic csr_access(input logic wr, input logic [mtct_pkg::CSR_DATA_W-1:0] data,
                             output logic [mtct_pkg::CSR_DATA_W-1:0] rd);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= mtct_pkg::CSR_ADDR_W'(4 * mtct_pkg::REG_MAX_LENGTH);
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_max_length(input int v);
      logic [mtct_pkg::CSR_DATA_W-1:0] rd;
      csr_access(1'b1, mtct_pkg::CSR_DATA_W'(v), rd);
      cfg_max_len = v;
      csr_access(1'b0, '0, rd);
      if (rd !== mtct_pkg::CSR_DATA_W'(v)) begin
         flag_mismatch($sformatf("max_length reads %0d, wrote %0d", rd, v));
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int len_limit;
      int chars_in_phase;
      int target;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            // limit only changes with the translator empty
            wait_drain();
            case (ph)
               1:       len_limit = 8;
               2:       len_limit = 1023;
               3:       len_limit = $urandom_range(9, 40);
               4:       len_limit = $urandom_range(41, 1022);
               5:       len_limit = 16;
               default: len_limit = $urandom_range(8, 24);
            endcase
            set_max_length(len_limit);
         end
         settings_run++;
         quiet = (ph == 2);
         chars_in_phase = 0;

         if (ph == 0) begin
            // directed tokens at the reset limit:
            // zero and all-ones bytes with brackets around nothing
            draft.push_back(mtct_pkg::CH_NUL);
            draft_str("()");
            draft.push_back(8'hFF);
            commit_token();
            // comparison name, arrow, then minus held up to the token end
            draft_str("<=->-");
            commit_token();
            // plus, bar, slash name, quote name, double spacer, caret, lone '='
            draft_str("+|/' ^=");
            commit_token();
            // full star-paren escape
            draft_str("\\*(ab");
            commit_token();
            // star-paren escape whose fourth char ends the token
            draft_str("\\*((");
            commit_token();
         end

         while (chars_in_phase < PHASE_WORDS - (ph == 0 ? 25 : 0)) begin
            target = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
            while (draft.size() < target) begin
               draft_piece();
            end
            chars_in_phase += draft.size();
            commit_token();
         end
      end

      wait_drain();
      $display("covered %0d tokens / %0d chars in, %0d bytes out, %0d refused appends",
               tokens_taken, words_taken, bytes_seen, refusals);
      $display("length limit settings: %0d, including 8 and 1023", settings_run);
      if (fails == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/mtct_pkg.sv
rtl/math_text_char_translator.sv
rtl/mtct_checker.sv
sim/tb.sv
